@@ design/wspv_pkg.sv @@
// Shared types, codes and helpers for the sample playback voice unit.
`default_nettype none

package wspv_pkg;

  localparam int VOICE_COUNT_DEF = 16;
  localparam int STORE_DEPTH_DEF = 65536;

  // item action codes
  localparam logic [1:0] ACT_LOAD     = 2'd0;
  localparam logic [1:0] ACT_NOTE_ON  = 2'd1;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd2;
  localparam logic [1:0] ACT_RENDER   = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_START_FRACTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FRACTION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_VOLUME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_RAMP_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LENGTH  = 3'd5;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         voice;
    logic [15:0]        frame_address;
    logic signed [15:0] frame_left;
    logic signed [15:0] frame_right;
    logic [23:0]        position_step;
    logic signed [15:0] fm_amount;
    logic [15:0]        envelope_level;
    logic               envelope_connected;
    logic [15:0]        steal_gain;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic [3:0]         out_voice;
    logic               finished;
  } result_t;

  typedef struct packed {
    logic [31:0] position;
    logic [16:0] gate_level;
    logic        gate_open;
  } voice_state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] num;
    logic [15:0] den;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] rem;
  } mod_rsp_t;

  // floor(x / 65535) for x <= 65535*65535
  function automatic logic [15:0] div65535(input logic [31:0] x);
    logic [32:0] t;
    t = {1'b0, x} + {17'd0, x[31:16]} + 33'd1;
    return t[31:16];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [20:0] x);
    logic signed [15:0] r;
    if (x > 21'sd32767) r = 16'sh7FFF;
    else if (x < -21'sd32768) r = 16'sh8000;
    else r = x[15:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/wspv_if.sv @@
// Valid/ready channel interfaces for items and results.
`default_nettype none

interface wspv_item_if
  import wspv_pkg::*;
  ();
  logic  valid;
  logic  ready;
  item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface wspv_result_if
  import wspv_pkg::*;
  ();
  logic    valid;
  logic    ready;
  result_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/wspv_mod_unit.sv @@
// Bit-serial restoring remainder unit, one quotient bit per cycle.
`default_nettype none

module wspv_mod_unit
  import wspv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mod_req_t req,
  output mod_rsp_t      rsp
);

  logic        busy;
  logic [3:0]  count;
  logic [15:0] num_sh;
  logic [15:0] den;
  logic [15:0] rem;
  logic        done;
  logic [16:0] trial;
  logic [15:0] rem_next;

  always_comb begin
    trial = {rem, num_sh[15]};
    if (trial >= {1'b0, den}) begin
      rem_next = 16'(trial - {1'b0, den});
    end else begin
      rem_next = trial[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= 4'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= 4'd0;
      end else if (busy) begin
        count <= count + 4'd1;
        if (count == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh <= req.num;
      den <= req.den;
      rem <= 16'd0;
    end else if (busy) begin
      num_sh <= {num_sh[14:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem = rem;

endmodule

`default_nettype wire

@@ design/windowed_sample_playback_voice_unit.sv @@
// Top level: multi-voice windowed sample player with linear interpolation.
//
//   channel   dir  handshake        beat contents
//   items     in   valid/ready      load frame, note on, note off, render tick
//   results   out  valid/ready      one stereo frame per render tick
//   cfg       in   cfg_we only      register index + data, no read-back
//
// Load beats write in-range frames to the store; the unit stays ready.
// Note on/off pass through the voice read, two window multiplies, decide.
// A render also fetches two frames, interpolates and runs the gain chain;
// a wrap first waits for the remainder unit. Early-out renders skip to emit.
// Reset clears control state and voice valid bits; the frame store is not
// cleared. A stalled result holds in the output register; the unit goes
// back to idle only once that register is free.
`default_nettype none

module windowed_sample_playback_voice_unit
  import wspv_pkg::*;
#(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  wspv_item_if.sink                  items,
  wspv_result_if.source              results,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LEN_CAP = (STORE_DEPTH < 65536) ? STORE_DEPTH : 65536;
  localparam logic [16:0] LEN_CAP_V = 17'(LEN_CAP);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_WIN_A  = 14'b00000000000010,
    S_WIN_B  = 14'b00000000000100,
    S_WIN_C  = 14'b00000000001000,
    S_DECIDE = 14'b00000000010000,
    S_MODW   = 14'b00000000100000,
    S_FETCH0 = 14'b00000001000000,
    S_FETCH1 = 14'b00000010000000,
    S_INTERP = 14'b00000100000000,
    S_MIXADD = 14'b00001000000000,
    S_GAIN   = 14'b00010000000000,
    S_VOL    = 14'b00100000000000,
    S_STEAL  = 14'b01000000000000,
    S_EMIT   = 14'b10000000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] start_fraction;
  logic [15:0] end_fraction;
  logic        cycle_enable;
  logic [15:0] output_volume;
  logic [16:0] gate_ramp_step;
  logic [16:0] sample_length;

  // item under work
  item_t        item;
  logic [VW-1:0] vidx;
  voice_state_t vst;
  logic [31:0]  prod_w;
  logic [15:0]  s_raw;
  logic [15:0]  lo;
  logic [15:0]  hi;
  logic [31:0]  pos;
  logic [15:0]  i0;
  logic [31:0]  s0;
  logic signed [35:0] pl_l;
  logic signed [35:0] pl_r;
  logic signed [16:0] mix_l;
  logic signed [16:0] mix_r;
  logic [39:0]  adv_prod;
  logic [16:0]  gain;
  logic         zero_out;
  logic         fin;

  result_t res;
  logic    res_valid;

  // memories
  logic [31:0]  store [STORE_DEPTH];
  logic [31:0]  store_q;
  logic [AW-1:0] store_raddr;
  logic         store_we;
  voice_state_t vmem [VOICE_COUNT];
  voice_state_t vmem_q;
  logic [VW-1:0] vm_raddr;
  logic         vm_we;
  voice_state_t vm_wdata;
  logic [VOICE_COUNT-1:0] vvalid;

  mod_req_t mreq;
  mod_rsp_t mrsp;

  // combinational datapath
  logic        accept;
  logic        voice_ok;
  logic [16:0] total;
  logic        short_sample;
  logic [15:0] len_m1;
  logic [15:0] len_m2;
  logic [15:0] frac_lo;
  logic [15:0] frac_hi;
  logic [15:0] s_c;
  logic [15:0] e_raw;
  logic [15:0] e_1;
  logic [15:0] e_c;
  logic [31:0] lo_sh;
  logic [31:0] hi_sh;
  logic [31:0] pos_c;
  logic        past_end;
  logic        wrap;
  logic [15:0] i0_c;
  logic signed [16:0] fm_sum;
  logic [15:0] fm_mult;
  logic [17:0] gsum;
  logic [16:0] gate_ramp;
  logic [16:0] gain_c;
  logic [32:0] psum;
  logic [31:0] pos_new;
  logic signed [15:0] l0, r0, l1, r1;
  logic signed [16:0] mul_a_l, mul_a_r;
  logic signed [17:0] mul_b;
  logic signed [34:0] prod_l, prod_r;

  assign accept = items.valid && items.ready;
  assign items.ready = (state == S_IDLE);
  assign voice_ok = {28'd0, items.payload.voice} < 32'(VOICE_COUNT);

  // usable length and window bounds
  assign total = (sample_length > LEN_CAP_V) ? LEN_CAP_V : sample_length;
  assign short_sample = total < 17'd2;
  assign len_m1 = 16'(total - 17'd1);
  assign len_m2 = 16'(total - 17'd2);
  // swapped bounds are reordered
  assign frac_lo = (start_fraction < end_fraction) ? start_fraction : end_fraction;
  assign frac_hi = (start_fraction < end_fraction) ? end_fraction : start_fraction;

  always_comb begin
    s_c = (s_raw > len_m2) ? len_m2 : s_raw;
    e_raw = div65535(prod_w);
    e_1 = (e_raw < 16'(s_c + 16'd1)) ? 16'(s_c + 16'd1) : e_raw;
    e_c = (e_1 > len_m1) ? len_m1 : e_1;
  end

  // position clamp and window end
  assign lo_sh = {lo, 16'd0};
  assign hi_sh = {hi, 16'd0};
  assign pos_c = (vst.position < lo_sh) ? lo_sh : vst.position;
  assign past_end = pos_c >= hi_sh;
  assign wrap = cycle_enable && vst.gate_open;
  assign i0_c = (pos[31:16] > len_m2) ? len_m2 : pos[31:16];

  // FM-scaled step multiplier, floored at zero
  assign fm_sum = 17'sd4096 + 17'(item.fm_amount);
  assign fm_mult = fm_sum[16] ? 16'd0 : fm_sum[15:0];

  // gate ramp toward full level while open, toward zero while closed; a connected envelope replaces it as gain
  always_comb begin
    gsum = {1'b0, vst.gate_level} + {1'b0, gate_ramp_step};
    if (vst.gate_open) begin
      gate_ramp = (gsum > 18'd65536) ? 17'd65536 : gsum[16:0];
    end else begin
      gate_ramp = (vst.gate_level > gate_ramp_step) ?
                  17'(vst.gate_level - gate_ramp_step) : 17'd0;
    end
    gain_c = item.envelope_connected ? {item.envelope_level, 1'b0} : gate_ramp;
  end

  // advanced position saturates at all ones
  assign psum = {1'b0, pos} + {5'd0, adv_prod[39:12]};
  assign pos_new = psum[32] ? 32'hFFFF_FFFF : psum[31:0];

  // frame halves: left in the low half
  assign l0 = signed'(s0[15:0]);
  assign r0 = signed'(s0[31:16]);
  assign l1 = signed'(store_q[15:0]);
  assign r1 = signed'(store_q[31:16]);

  // one shared multiplier per channel for interpolation and the gain chain
  always_comb begin
    mul_a_l = signed'(pl_l[32:16]);
    mul_a_r = signed'(pl_r[32:16]);
    mul_b = signed'({2'b00, item.steal_gain});
    case (state)
      S_INTERP: begin
        mul_a_l = 17'(l1) - 17'(l0);
        mul_a_r = 17'(r1) - 17'(r0);
        mul_b = signed'({2'b00, pos[15:0]});
      end
      S_GAIN: begin
        mul_a_l = mix_l;
        mul_a_r = mix_r;
        mul_b = signed'({1'b0, gain});
      end
      S_VOL: begin
        mul_b = signed'({2'b00, output_volume});
      end
      default: begin
      end
    endcase
    prod_l = mul_a_l * mul_b;
    prod_r = mul_a_r * mul_b;
  end

  // frame store: one write port on load, one registered read port
  assign store_we = accept && (items.payload.action == ACT_LOAD) &&
                    ({16'd0, items.payload.frame_address} < 32'(STORE_DEPTH));
  assign store_raddr = (state == S_FETCH0) ? AW'(i0_c) : AW'(16'(i0 + 16'd1));

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[AW'(items.payload.frame_address)] <=
        {items.payload.frame_right, items.payload.frame_left};
    end
    store_q <= store[store_raddr];
  end

  // voice state memory, read at accept, written at most once per item, in decide or mix-add
  assign vm_raddr = (state == S_IDLE) ? VW'(items.payload.voice) : vidx;

  always_comb begin
    vm_we = 1'b0;
    vm_wdata = vst;
    unique case (state)
      S_DECIDE: begin
        if (item.action == ACT_NOTE_ON) begin
          vm_we = 1'b1;
          vm_wdata.position = short_sample ? 32'd0 : lo_sh;
          vm_wdata.gate_level = 17'd0;
          vm_wdata.gate_open = 1'b1;
        end else if (item.action == ACT_NOTE_OFF) begin
          vm_we = 1'b1;
          vm_wdata.gate_open = 1'b0;
        end else if (item.steal_gain != 16'd0 && !short_sample && past_end && !wrap) begin
          // silent past the window end: keep the clamped position
          vm_we = 1'b1;
          vm_wdata.position = pos_c;
        end
      end
      S_MIXADD: begin
        vm_we = 1'b1;
        vm_wdata.position = pos_new;
        vm_wdata.gate_level = item.envelope_connected ? vst.gate_level : gate_ramp;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[vidx] <= vm_wdata;
    end
    vmem_q <= vmem[vm_raddr];
  end

  // wrap: ((int - lo) mod span), fraction kept as is
  assign mreq.start = (state == S_DECIDE) && (item.action == ACT_RENDER) &&
                      (item.steal_gain != 16'd0) && !short_sample && past_end && wrap;
  assign mreq.num = 16'(pos_c[31:16] - lo);
  assign mreq.den = 16'(hi - lo);

  wspv_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      vvalid <= '0;
      start_fraction <= 16'd0;
      end_fraction <= 16'd65535;
      cycle_enable <= 1'b0;
      output_volume <= 16'd52428;
      gate_ramp_step <= 17'd273;
      sample_length <= 17'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_FRACTION: start_fraction <= cfg_data[15:0];
          CFG_END_FRACTION:   end_fraction <= cfg_data[15:0];
          CFG_CYCLE_ENABLE:   cycle_enable <= cfg_data[0];
          CFG_OUTPUT_VOLUME:  output_volume <= cfg_data[15:0];
          CFG_GATE_RAMP_STEP: gate_ramp_step <= cfg_data;
          CFG_SAMPLE_LENGTH:  sample_length <= cfg_data;
          default: begin
          end
        endcase
      end

      if (vm_we) begin
        vvalid[vidx] <= 1'b1;
      end

      // output register: loaded from EMIT, freed by the sink
      if (state == S_EMIT && (!res_valid || results.ready)) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && items.payload.action != ACT_LOAD && voice_ok) begin
            state <= S_WIN_A;
          end
        end
        S_WIN_A: state <= S_WIN_B;
        S_WIN_B: state <= S_WIN_C;
        S_WIN_C: state <= S_DECIDE;
        S_DECIDE: begin
          if (item.action != ACT_RENDER) begin
            state <= S_IDLE;
          end else if (item.steal_gain == 16'd0 || short_sample || (past_end && !wrap)) begin
            state <= S_EMIT;
          end else if (past_end) begin
            state <= S_MODW;
          end else begin
            state <= S_FETCH0;
          end
        end
        S_MODW: begin
          if (mrsp.done) begin
            state <= S_FETCH0;
          end
        end
        S_FETCH0: state <= S_FETCH1;
        S_FETCH1: state <= S_INTERP;
        S_INTERP: state <= S_MIXADD;
        S_MIXADD: state <= S_GAIN;
        S_GAIN:   state <= S_VOL;
        S_VOL:    state <= S_STEAL;
        S_STEAL:  state <= S_EMIT;
        S_EMIT: begin
          if (!res_valid || results.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          item <= items.payload;
          vidx <= VW'(items.payload.voice);
        end
      end
      S_WIN_A: begin
        vst <= vvalid[vidx] ? vmem_q : '0;
        prod_w <= {16'd0, frac_lo} * {16'd0, len_m1};
      end
      S_WIN_B: begin
        s_raw <= div65535(prod_w);
        prod_w <= {16'd0, frac_hi} * {16'd0, len_m1};
      end
      S_WIN_C: begin
        lo <= s_c;
        hi <= e_c;
      end
      S_DECIDE: begin
        zero_out <= 1'b1;
        fin <= (item.steal_gain != 16'd0);
        pos <= pos_c;
      end
      S_MODW: begin
        if (mrsp.done) begin
          pos <= {16'(lo + mrsp.rem), pos[15:0]};
        end
      end
      S_FETCH0: i0 <= i0_c;
      S_FETCH1: s0 <= store_q;
      S_INTERP: begin
        pl_l <= 36'(prod_l);
        pl_r <= 36'(prod_r);
        adv_prod <= {16'd0, item.position_step} * {24'd0, fm_mult};
      end
      S_MIXADD: begin
        mix_l <= 17'(l0) + signed'(pl_l[32:16]);
        mix_r <= 17'(r0) + signed'(pl_r[32:16]);
        gain <= gain_c;
        zero_out <= 1'b0;
        fin <= 1'b0;
      end
      S_GAIN, S_VOL, S_STEAL: begin
        pl_l <= 36'(prod_l);
        pl_r <= 36'(prod_r);
      end
      S_EMIT: begin
        if (!res_valid || results.ready) begin
          res.out_left <= zero_out ? 16'sd0 : sat16(pl_l[35:15]);
          res.out_right <= zero_out ? 16'sd0 : sat16(pl_r[35:15]);
          res.out_voice <= item.voice;
          res.finished <= fin;
        end
      end
      default: begin
      end
    endcase
  end

  assign results.valid = res_valid;
  assign results.payload = res;

endmodule

`default_nettype wire

@@ design/wspv_checker.sv @@
// Port-level checks for the sample playback voice unit, bound to the top level.
`default_nettype none

module wspv_checker
  import wspv_pkg::*;
#(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  wspv_item_if.sink     items,
  wspv_result_if.source results
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !results.valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=> results.valid && $stable(results.payload))
    else $error("stalled result changed");

  // the unit is ready again in the cycle after a load
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready && items.payload.action == ACT_LOAD |=> items.ready)
    else $error("not ready after load");

  // a finished voice is silent
  a_fin_silent: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.payload.finished |->
      results.payload.out_left == 16'sd0 && results.payload.out_right == 16'sd0)
    else $error("finished voice not silent");

  // results only from voices in range
  a_voice_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> {28'd0, results.payload.out_voice} < 32'(VOICE_COUNT))
    else $error("result voice out of range");

endmodule

bind windowed_sample_playback_voice_unit wspv_checker #(
  .VOICE_COUNT(VOICE_COUNT)
) u_wspv_checker (
  .clk     (clk),
  .rst     (rst),
  .items   (items),
  .results (results)
);

`default_nettype wire
